/* rtl/core/gb5_pkg.sv */
`timescale 1ns / 1ps

package gb5_pkg;

    // Configuration register widths and indexes.
    localparam int CfgW    = 11;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CfgW-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [CfgW-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    // Window geometry and packed pixel layout.
    localparam int Span   = 5;
    localparam int Lines  = Span - 1;
    localparam int PixW   = 24;
    localparam int WordW  = PixW * Lines;
    localparam int RowSumW = 12;
    localparam int ColSumW = 16;
    localparam int PosW   = 10;

    typedef logic [PixW-1:0]    pix_t;
    typedef logic [RowSumW-1:0] rowsum_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0]      out_red;
        logic [7:0]      out_green;
        logic [7:0]      out_blue;
        logic [PosW-1:0] out_row;
        logic [PosW-1:0] out_col;
        logic            last_of_frame;
    } blur_t;

    // Position data that travels with an emitted pixel.
    typedef struct packed {
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
        logic            last;
    } pos_t;

    // Horizontal 1-4-6-4-1 sum of one channel across one window row.
    function automatic rowsum_t tap5_row(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [7:0] d,
                                         input logic [7:0] e);
        rowsum_t ea, eb, ec, ed, ee;
        ea = {4'd0, a};
        eb = {4'd0, b};
        ec = {4'd0, c};
        ed = {4'd0, d};
        ee = {4'd0, e};
        return ea + (eb << 2) + (ec << 2) + (ec << 1) + (ed << 2) + ee;
    endfunction

    // Vertical 1-4-6-4-1 combination of five row sums.
    function automatic logic [ColSumW-1:0] tap5_col(input rowsum_t a, input rowsum_t b,
                                                    input rowsum_t c, input rowsum_t d,
                                                    input rowsum_t e);
        logic [ColSumW-1:0] ea, eb, ec, ed, ee;
        ea = {4'd0, a};
        eb = {4'd0, b};
        ec = {4'd0, c};
        ed = {4'd0, d};
        ee = {4'd0, e};
        return ea + (eb << 2) + (ec << 2) + (ec << 1) + (ed << 2) + ee;
    endfunction

endpackage

/* rtl/core/gb5_line_store.sv */
`timescale 1ns / 1ps

module gb5_line_store #(
    parameter int Depth = 1028,
    parameter int AddrW = 11,
    parameter int DataW = 96
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [DataW-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [DataW-1:0] wr_data
);

    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read at the address being written returns the old word; the caller forwards.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/gaussian_blur_5x5_rgb.sv */
`timescale 1ns / 1ps

// Channel   Handshake               Payload    Direction
// pixel     pixel_valid/pixel_stall pixel_t    into block, padded frame in raster order
// blur      blur_valid/blur_stall   blur_t     out of block, one per interior pixel
// cfg       cfg_we                  cfg_data   register writes, index by cfg_index
//
// One pixel is taken every clock while pixel_stall is low; after its pixel transfer a
// blurred pixel passes the line store read, window, row sums and output register.
// The single-port-per-direction line store is read once and written once per pixel.
// Reset clears the position counters, the window and the pipeline; the line store
// is not cleared. pixel_stall rises only when the output register is held by
// blur_stall and every stage behind it is occupied.

module gaussian_blur_5x5_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  gb5_pkg::pixel_t               pixel,
    output logic                          blur_valid,
    input  logic                          blur_stall,
    output gb5_pkg::blur_t                blur,
    input  logic                          cfg_we,
    input  logic [gb5_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [gb5_pkg::CfgW-1:0]      cfg_data
);

    import gb5_pkg::*;

    localparam int Depth = MAX_WIDTH + 4;
    localparam int AddrW = $clog2(Depth);
    localparam int ColW  = $clog2(MAX_WIDTH + 5);
    localparam int RowW  = $clog2(MAX_HEIGHT + 5);
    localparam int ExtWW = (ColW > CfgW) ? ColW : CfgW;
    localparam int ExtHW = (RowW > CfgW) ? RowW : CfgW;
    localparam logic [ExtWW-1:0] MaxWExt = ExtWW'(MAX_WIDTH);
    localparam logic [ExtHW-1:0] MaxHExt = ExtHW'(MAX_HEIGHT);

    // Configuration.
    logic [CfgW-1:0] img_w_reg, img_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= IMAGE_WIDTH_RESET;
            img_h_reg <= IMAGE_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective geometry: zero acts as one, large values clip to the maximum.
    logic [ExtWW-1:0] w_ext;
    logic [ExtHW-1:0] h_ext;
    logic [ColW-1:0]  w_eff, pw;
    logic [RowW-1:0]  h_eff, ph;

    always_comb
    begin
        w_ext = ExtWW'(img_w_reg);
        h_ext = ExtHW'(img_h_reg);
        if (w_ext == '0)
            w_ext = ExtWW'(1);
        else if (w_ext > MaxWExt)
            w_ext = MaxWExt;
        if (h_ext == '0)
            h_ext = ExtHW'(1);
        else if (h_ext > MaxHExt)
            h_ext = MaxHExt;
        w_eff = w_ext[ColW-1:0];
        h_eff = h_ext[RowW-1:0];
        pw    = w_eff + ColW'(4);
        ph    = h_eff + RowW'(4);
    end

    // Pipeline control.
    logic accept, s1_go, s2_go, s3_go;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;

    assign s3_go       = s3_valid_reg && (!out_valid_reg || !blur_stall);
    assign s2_go       = s2_valid_reg && (!s3_valid_reg || s3_go);
    assign s1_go       = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign pixel_stall = s1_valid_reg && !s1_go;
    assign accept      = pixel_valid && !pixel_stall;

    // Position counters.
    logic [ColW-1:0] col_reg, col_next, c_cur, c_inc;
    logic [RowW-1:0] row_reg, row_next, r_cur, r_inc;
    logic            emit;
    logic            last;
    logic [RowW+PosW-1:0] orow_ext;
    logic [ColW+PosW-1:0] ocol_ext;

    always_comb
    begin
        c_cur = pixel.frame_start ? '0 : col_reg;
        r_cur = pixel.frame_start ? '0 : row_reg;
        if (c_cur >= pw)
        begin
            c_cur = '0;
            r_cur = r_cur + RowW'(1);
        end
        if (r_cur >= ph)
            r_cur = '0;

        c_inc = c_cur + ColW'(1);
        r_inc = r_cur + RowW'(1);
        if (c_inc >= pw)
        begin
            col_next = '0;
            row_next = (r_inc >= ph) ? '0 : r_inc;
        end
        else
        begin
            col_next = c_inc;
            row_next = r_cur;
        end

        emit     = (r_cur >= RowW'(4)) && (c_cur >= ColW'(4));
        last     = (r_cur == h_eff + RowW'(3)) && (c_cur == w_eff + ColW'(3));
        orow_ext = {{PosW{1'b0}}, r_cur - RowW'(4)};
        ocol_ext = {{PosW{1'b0}}, c_cur - ColW'(4)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line store word arrives; read-modify-write with forwarding.
    logic [AddrW-1:0] rd_addr;
    logic [WordW-1:0] rd_data, s1_old, s1_word;
    logic [AddrW-1:0] s1_addr_reg;
    pix_t             s1_pix_reg;
    logic             s1_emit_reg;
    pos_t             s1_pos_reg;
    logic             s1_fwd_reg;
    logic [WordW-1:0] s1_fwd_data_reg;

    assign rd_addr = c_cur[AddrW-1:0];
    assign s1_old  = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
    assign s1_word = {s1_pix_reg, s1_old[WordW-1:PixW]};

    gb5_line_store #(
        .Depth(Depth),
        .AddrW(AddrW),
        .DataW(WordW)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            // The older item writes this address at the same edge as the read.
            s1_fwd_reg   <= s1_valid_reg && (s1_addr_reg == rd_addr);
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg     <= rd_addr;
            s1_pix_reg      <= {pixel.in_red, pixel.in_green, pixel.in_blue};
            s1_emit_reg     <= emit;
            s1_pos_reg      <= '{row: orow_ext[PosW-1:0], col: ocol_ext[PosW-1:0], last: last};
            s1_fwd_data_reg <= s1_word;
        end
    end

    // Stage 2: the window, valid while it holds an emitting neighbourhood.
    pix_t win_reg [Span][Span];
    pos_t s2_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Span; i++)
            begin
                for (int j = 0; j < Span; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_go)
        begin
            for (int i = 0; i < Span; i++)
            begin
                for (int j = 0; j < Span - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
            end
            for (int i = 0; i < Lines; i++)
            begin
                win_reg[i][Span-1] <= s1_old[PixW*i +: PixW];
            end
            win_reg[Span-1][Span-1] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_go)
            s2_valid_reg <= s1_emit_reg;
        else if (s2_go)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
            s2_pos_reg <= s1_pos_reg;
    end

    // Stage 3: horizontal sums for each row and channel.
    rowsum_t hsum [Span][3];
    rowsum_t hsum_reg [Span][3];
    pos_t    s3_pos_reg;

    always_comb
    begin
        for (int i = 0; i < Span; i++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                hsum[i][ch] = tap5_row(win_reg[i][0][8*ch +: 8], win_reg[i][1][8*ch +: 8],
                                       win_reg[i][2][8*ch +: 8], win_reg[i][3][8*ch +: 8],
                                       win_reg[i][4][8*ch +: 8]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s2_go)
            s3_valid_reg <= 1'b1;
        else if (s3_go)
            s3_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            hsum_reg   <= hsum;
            s3_pos_reg <= s2_pos_reg;
        end
    end

    // Output register: vertical combination and the divide by 256.
    logic [ColSumW-1:0] vsum [3];
    blur_t              blur_next, blur_reg;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            vsum[ch] = tap5_col(hsum_reg[0][ch], hsum_reg[1][ch], hsum_reg[2][ch],
                                hsum_reg[3][ch], hsum_reg[4][ch]);
        end
        // Channel 0 is blue, channel 2 is red, as packed in the pixel word.
        blur_next.out_red       = vsum[2][ColSumW-1:8];
        blur_next.out_green     = vsum[1][ColSumW-1:8];
        blur_next.out_blue      = vsum[0][ColSumW-1:8];
        blur_next.out_row       = s3_pos_reg.row;
        blur_next.out_col       = s3_pos_reg.col;
        blur_next.last_of_frame = s3_pos_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s3_go)
            out_valid_reg <= 1'b1;
        else if (!blur_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s3_go)
            blur_reg <= blur_next;
    end

    assign blur_valid = out_valid_reg;
    assign blur       = blur_reg;

`ifndef SYNTH
    // A frame start always lands on padded column zero, row zero.
    a_frame_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pixel.frame_start |=> col_reg == ColW'(1) && row_reg == '0)
        else $error("frame start did not restart the position counters");

    // A read that collides with the pending write must take the forwarded word.
    a_forward_taken: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg && (s1_addr_reg == rd_addr) |=> s1_fwd_reg)
        else $error("line store read-after-write collision not forwarded");

    // The window must not move while its neighbourhood waits for the row-sum stage.
    a_window_held: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_go |=> s2_valid_reg && $stable(s2_pos_reg) && !$past(s1_go))
        else $error("window changed under a pending neighbourhood");
`endif

endmodule

/* sim/blur_checker.sv */
`timescale 1ns / 1ps

module blur_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    input  logic                        pixel_stall,
    input  gb5_pkg::pixel_t             pixel,
    input  logic                        blur_valid,
    input  logic                        blur_stall,
    input  gb5_pkg::blur_t              blur,
    input  logic                        cfg_we,
    input  logic [gb5_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [gb5_pkg::CfgW-1:0]    cfg_data,
    output int                          failures,
    output int                          pending,
    output int                          blurs_checked
);

    import gb5_pkg::*;

    localparam int LineLen = MAX_WIDTH + 4;

    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    pix_t            line_mem [0:Lines-1][0:LineLen-1];
    pix_t            win [0:Span-1][0:Span-1];
    int              col_cnt;
    int              row_cnt;
    blur_t           expected_blurs [$];
    blur_t           want_blur;

    function automatic int eff_dim(input logic [CfgW-1:0] v, input int maxv);
        if (v == 0)
        begin
            return 1;
        end
        if (int'(v) > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic int unsigned tap(input int k);
        case (k)
            0, 4: return 1;
            1, 3: return 4;
            default: return 6;
        endcase
    endfunction

    function automatic logic [7:0] blur_chan(input int sh);
        int unsigned acc;
        int          i;
        int          j;
        acc = 0;
        for (i = 0; i < Span; i++)
        begin
            for (j = 0; j < Span; j++)
            begin
                acc += tap(i) * tap(j) * win[i][j][sh +: 8];
            end
        end
        return acc[15:8];
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        failures++;
    endtask

    // Moves the window and line stores by one pixel and queues the blurred pixel
    // when the window covers a full interior neighbourhood.
    task automatic advance_window(input pixel_t p);
        int    w;
        int    h;
        int    pw;
        int    ph;
        int    r;
        int    c;
        int    i;
        int    j;
        pix_t  np;
        blur_t e;
        w  = eff_dim(width_reg, MAX_WIDTH);
        h  = eff_dim(height_reg, MAX_HEIGHT);
        pw = w + 4;
        ph = h + 4;
        np = {p.in_red, p.in_green, p.in_blue};
        if (p.frame_start)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // A geometry change may leave the counters outside the new frame.
        if (col_cnt >= pw)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= ph)
        begin
            row_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt;
        for (i = 0; i < Span; i++)
        begin
            for (j = 0; j < Span - 1; j++)
            begin
                win[i][j] = win[i][j+1];
            end
        end
        for (i = 0; i < Lines; i++)
        begin
            win[i][Span-1] = line_mem[i][c];
        end
        win[Span-1][Span-1] = np;
        for (i = 0; i < Lines - 1; i++)
        begin
            line_mem[i][c] = line_mem[i+1][c];
        end
        line_mem[Lines-1][c] = np;
        if (r >= 4 && c >= 4)
        begin
            e.out_red       = blur_chan(16);
            e.out_green     = blur_chan(8);
            e.out_blue      = blur_chan(0);
            e.out_row       = PosW'(r - 4);
            e.out_col       = PosW'(c - 4);
            e.last_of_frame = (r - 4 == h - 1) && (c - 4 == w - 1);
            expected_blurs.push_back(e);
        end
        col_cnt++;
        if (col_cnt >= pw)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= ph)
            begin
                row_cnt = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = IMAGE_WIDTH_RESET;
            height_reg = IMAGE_HEIGHT_RESET;
            col_cnt    = 0;
            row_cnt    = 0;
            for (int i = 0; i < Span; i++)
            begin
                for (int j = 0; j < Span; j++)
                begin
                    win[i][j] = '0;
                end
            end
            for (int i = 0; i < Lines; i++)
            begin
                for (int j = 0; j < LineLen; j++)
                begin
                    line_mem[i][j] = '0;
                end
            end
            expected_blurs.delete();
            failures      = 0;
            blurs_checked = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == REG_IMAGE_HEIGHT)
                begin
                    height_reg = cfg_data;
                end
            end
            if (pixel_valid && !pixel_stall)
            begin
                advance_window(pixel);
            end
            if (blur_valid && !blur_stall)
            begin
                if (expected_blurs.size() == 0)
                begin
                    report($sformatf("blur transfer %0d with nothing expected (row %0d col %0d)",
                                     blurs_checked, blur.out_row, blur.out_col));
                end
                else
                begin
                    want_blur = expected_blurs.pop_front();
                    if (blur.out_red !== want_blur.out_red)
                        report($sformatf("blur %0d out_red got %0d want %0d", blurs_checked,
                                         blur.out_red, want_blur.out_red));
                    if (blur.out_green !== want_blur.out_green)
                        report($sformatf("blur %0d out_green got %0d want %0d", blurs_checked,
                                         blur.out_green, want_blur.out_green));
                    if (blur.out_blue !== want_blur.out_blue)
                        report($sformatf("blur %0d out_blue got %0d want %0d", blurs_checked,
                                         blur.out_blue, want_blur.out_blue));
                    if (blur.out_row !== want_blur.out_row)
                        report($sformatf("blur %0d out_row got %0d want %0d", blurs_checked,
                                         blur.out_row, want_blur.out_row));
                    if (blur.out_col !== want_blur.out_col)
                        report($sformatf("blur %0d out_col got %0d want %0d", blurs_checked,
                                         blur.out_col, want_blur.out_col));
                    if (blur.last_of_frame !== want_blur.last_of_frame)
                        report($sformatf("blur %0d last_of_frame got %0d want %0d", blurs_checked,
                                         blur.last_of_frame, want_blur.last_of_frame));
                end
                blurs_checked++;
            end
            pending <= expected_blurs.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import gb5_pkg::*;

    localparam int MaxDim     = 1024;
    localparam int CycleLimit = 600000;
    localparam int IdlePct    = 31;

    typedef enum int {PAT_RANDOM, PAT_FULL, PAT_ALT} pattern_e;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               pixel_valid = 1'b0;
    logic               pixel_stall;
    pixel_t             pixel       = '0;
    logic               blur_valid;
    logic               blur_stall  = 1'b0;
    blur_t              blur;
    logic               cfg_we      = 1'b0;
    logic [CfgIdxW-1:0] cfg_index   = '0;
    logic [CfgW-1:0]    cfg_data    = '0;

    int          failures;
    int          pending;
    int          blurs_checked;
    bit          calm        = 1'b0;
    int unsigned cycles      = 0;
    int          pixels_sent = 0;
    int          geometries  = 0;

    gaussian_blur_5x5_rgb #(
        .MAX_WIDTH  (MaxDim),
        .MAX_HEIGHT (MaxDim)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .blur_valid  (blur_valid),
        .blur_stall  (blur_stall),
        .blur        (blur),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    blur_checker #(
        .MAX_WIDTH  (MaxDim),
        .MAX_HEIGHT (MaxDim)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .blur_valid    (blur_valid),
        .blur_stall    (blur_stall),
        .blur          (blur),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .pending       (pending),
        .blurs_checked (blurs_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        blur_stall <= (calm || !rst_n) ? 1'b0 : ($urandom_range(99) < IdlePct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles with %0d blurred pixels outstanding",
                     cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int eff_dim(input int v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > MaxDim) ? MaxDim : v;
    endfunction

    task automatic set_geometry(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w[CfgW-1:0];
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h[CfgW-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        geometries++;
    endtask

    // Sends count pixels; stray adds the odd frame_start in mid-frame.
    task automatic send_pixels(input int count, input bit mark_first, input pattern_e pat,
                               input bit stray);
        pixel_t p;
        int     k;
        for (k = 0; k < count; k++)
        begin
            case (pat)
                PAT_FULL:
                begin
                    p.in_red   = 8'hFF;
                    p.in_green = 8'hFF;
                    p.in_blue  = 8'hFF;
                end
                PAT_ALT:
                begin
                    p.in_red   = k[0] ? 8'hFF : 8'h00;
                    p.in_green = k[0] ? 8'h00 : 8'hFF;
                    p.in_blue  = k[1] ? 8'hFF : 8'h00;
                end
                default:
                begin
                    p.in_red   = 8'($urandom_range(255));
                    p.in_green = 8'($urandom_range(255));
                    p.in_blue  = 8'($urandom_range(255));
                end
            endcase
            p.frame_start = (k == 0 && mark_first) || (stray && k > 0 && $urandom_range(99) < 3);
            while (!calm && $urandom_range(99) < IdlePct)
            begin
                pixel_valid <= 1'b0;
                @(posedge clk);
            end
            pixel_valid <= 1'b1;
            pixel       <= p;
            @(posedge clk);
            while (pixel_stall)
            begin
                @(posedge clk);
            end
            pixels_sent++;
        end
    endtask

    // Returns once every predicted pixel has come out and the pipeline has drained.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int w_reg;
        int h_reg;
        int pw;
        int ph;
        int roll;
        int random_base;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame: saturated pixels, a cut frame, alternating extremes,
        // and a frame that follows the wrap with no frame_start.
        set_geometry(1, 1);
        send_pixels(25, 1'b1, PAT_FULL, 1'b0);
        send_pixels(7, 1'b1, PAT_ALT, 1'b0);
        send_pixels(25, 1'b1, PAT_ALT, 1'b0);
        send_pixels(25, 1'b0, PAT_RANDOM, 1'b0);
        wait_idle();

        // A frame as wide as the widest random frame below, so that every line
        // store column those frames can reach has been written. This stretch and
        // the next two frames run with neither side idling.
        calm <= 1'b1;
        set_geometry(16, 1);
        send_pixels(20 * 5, 1'b1, PAT_RANDOM, 1'b0);
        wait_idle();

        // Register extremes; zero acts as one and values past the maximum clamp.
        // Tall frames are cut after a few rows.
        set_geometry(2047, 0);
        send_pixels(24, 1'b1, PAT_RANDOM, 1'b0);
        wait_idle();
        set_geometry(0, 2047);
        send_pixels(5 * 9, 1'b1, PAT_RANDOM, 1'b0);
        wait_idle();
        calm <= 1'b0;
        set_geometry(1, 1024);
        send_pixels(5 * 7, 1'b1, PAT_FULL, 1'b0);
        wait_idle();
        set_geometry(0, 0);
        send_pixels(25, 1'b1, PAT_RANDOM, 1'b0);
        wait_idle();

        // Geometry changed part way through a frame. Every line store column these
        // frames reach was written by the wide frame above, so stale reads are well
        // defined.
        set_geometry(6, 4);
        send_pixels(10 * 5 + 7, 1'b1, PAT_RANDOM, 1'b0);
        wait_idle();
        set_geometry(3, 4);
        send_pixels(7 * 8 * 2, 1'b0, PAT_RANDOM, 1'b0);
        wait_idle();
        set_geometry(5, 6);
        send_pixels(9 * 8 + 3, 1'b1, PAT_RANDOM, 1'b0);
        wait_idle();
        set_geometry(5, 1);
        send_pixels(9 * 5 * 2, 1'b0, PAT_RANDOM, 1'b0);
        wait_idle();

        random_base = pixels_sent;
        while (pixels_sent - random_base < 120)
        begin
            if ($urandom_range(19) == 0)
                w_reg = 0;
            else if ($urandom_range(9) == 0)
                w_reg = $urandom_range(7, 16);
            else
                w_reg = $urandom_range(1, 6);
            h_reg = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
            set_geometry(w_reg, h_reg);
            pw = eff_dim(w_reg) + 4;
            ph = eff_dim(h_reg) + 4;
            repeat ($urandom_range(1, 3))
            begin
                roll = $urandom_range(99);
                if (roll < 10)
                begin
                    send_pixels($urandom_range(1, pw * ph - 1), 1'b1, PAT_RANDOM, 1'b0);
                    send_pixels(pw * ph, 1'b1, PAT_RANDOM, 1'b0);
                end
                else if (roll < 20)
                begin
                    send_pixels(pw * ph, 1'b1, PAT_RANDOM, 1'b1);
                end
                else
                begin
                    send_pixels(pw * ph, roll >= 40, PAT_RANDOM, 1'b0);
                end
            end
            wait_idle();
        end

        wait_idle();
        $display("run covered %0d pixel transfers and %0d blurred-pixel transfers over %0d geometries",
                 pixels_sent, blurs_checked, geometries);
        $display("including both register extremes, mid-frame geometry changes, cut frames and stray frame starts");
        if (failures == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
